@@ design/ddo_pkg.sv @@
`timescale 1ns / 1ps

package ddo_pkg;

    // Default build-time settings
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Fixed-point constants
    localparam logic [31:0]        TWO_PI_Q16      = 32'd411775;
    localparam logic [31:0]        TURN_PER_RAD    = 32'd683565276;
    localparam logic [31:0]        US_PER_S        = 32'd1000000;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Datapath widths
    localparam int DIV_W  = 64;
    localparam int DVS_W  = 24;
    localparam int MUL_W  = 32;
    localparam int TRV_W  = 56;
    localparam int CNT_W  = 6;
    localparam int COR_IW = 5;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_WHEEL_RADIUS  = 2'd0,
        CFG_AXLE_WIDTH    = 2'd1,
        CFG_TICKS_PER_REV = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_W_MUL,
        ST_W_LOAD,
        ST_W_DIV,
        ST_W_HI,
        ST_W_LO,
        ST_W_SUM,
        ST_COMB,
        ST_RAD_DIV,
        ST_RAD_SAVE,
        ST_FS_LO,
        ST_FS_HI,
        ST_FS_LOAD,
        ST_FS_DIV,
        ST_YR_LO,
        ST_YR_HI,
        ST_YR_LOAD,
        ST_YR_DIV,
        ST_INC_HI,
        ST_INC_LO,
        ST_INC_SUM,
        ST_COR_INIT,
        ST_COR_STEP,
        ST_PX_MUL,
        ST_PX_ADD,
        ST_PY_ADD,
        ST_DONE
    } state_t;

    // Arctangent of 2^-i in 32-bit binary angle units
    function automatic logic [31:0] atan_turn(input logic [COR_IW-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10680862;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Apply a sign to a magnitude and clamp to 32 bits
    function automatic logic [31:0] signed_sat(input logic neg, input logic [63:0] mag);
        logic [31:0] v;
        if (!neg) begin
            v = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end else begin
            v = (mag >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        end
        return v;
    endfunction

    // Clamp a signed sum to 32 bits
    function automatic logic [31:0] sat32(input logic signed [64:0] v);
        logic [31:0] r;
        if (v > 65'sh0_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -65'sh0_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ design/differential_drive_odometry.sv @@
// Channel   Direction  Payload                                          Handshake
// s_        in         tdata: right_ticks, left_ticks, elapsed_us       s_tvalid/s_tready
// m_        out        tdata: x_pos, y_pos, heading, forward_speed,     m_tvalid/m_tready
//                             yaw_rate; tuser: no_time_flag
// cfg_      in         cfg_index, cfg_data (register write)             cfg_valid/cfg_ready
//
// A request takes fewer steps when a speed saturates or the elapsed time is zero.
// Most of its steps are five passes of the shared radix-2 divider; the shared
// 32x32 multiplier forms the products and the CORDIC performs the rotations.
// s_tready is high only in idle; a waiting result does not block a new request,
// the sequencer holds in its last step until the previous result is taken.
// aresetn is synchronous and active low; it restores the register defaults and
// clears the pose and the last counts.
`timescale 1ns / 1ps

module differential_drive_odometry #(
    parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // right_ticks[31:0], left_ticks[63:32], elapsed_us[87:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // x_pos[31:0], y_pos[63:32], heading[79:64],
                                    // forward_speed[111:80], yaw_rate[143:112]
    output logic         m_tuser,   // no_time_flag[0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [17:0]  cfg_data
);

    localparam logic [31:0] ANGLE_KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    localparam logic [ddo_pkg::CNT_W-1:0] COR_LAST = ddo_pkg::CNT_W'(CORDIC_STEPS - 1);
    localparam logic [ddo_pkg::CNT_W-1:0] DIV_LAST = ddo_pkg::CNT_W'(ddo_pkg::DIV_W - 1);

    ddo_pkg::state_t state_reg, state_next;

    logic [15:0] radius_reg, radius_next;
    logic [17:0] axle_reg, axle_next;
    logic [15:0] tpr_reg, tpr_next;

    logic [31:0] in_r_reg, in_r_next, in_l_reg, in_l_next;
    logic [23:0] dt_reg, dt_next;
    logic [31:0] last_r_reg, last_r_next, last_l_reg, last_l_next;
    logic [31:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [31:0] yaw_reg, yaw_next;
    logic        wsel_reg, wsel_next;

    logic signed [ddo_pkg::TRV_W-1:0] dr_reg, dr_next, dl_reg, dl_next;
    logic [ddo_pkg::TRV_W-1:0] fmag_reg, fmag_next;
    logic        fneg_reg, fneg_next, yneg_reg, yneg_next;
    logic [31:0] fdc_mag_reg, fdc_mag_next;
    logic [63:0] rad_reg, rad_next;

    logic [ddo_pkg::DIV_W-1:0] num_reg, num_next;
    logic [ddo_pkg::DVS_W-1:0] rem_reg, rem_next, dvs_reg, dvs_next;
    logic [ddo_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0] prod_reg, prod_next, acc_reg, acc_next;
    logic [ddo_pkg::MUL_W-1:0] mul_a, mul_b;

    logic [31:0] fspeed_reg, fspeed_next, yrate_reg, yrate_next, inc_reg, inc_next;
    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [32:0] cz_reg, cz_next;
    logic        flip_reg, flip_next;

    logic [143:0] m_data_reg, m_data_next;
    logic         m_user_reg, m_user_next;
    logic         m_valid_reg, m_valid_next;

    // Shared divider step
    logic [ddo_pkg::DVS_W:0]   div_r2, div_sub;
    logic                      div_ge;
    logic [ddo_pkg::DIV_W-1:0] div_num;
    logic [ddo_pkg::DVS_W-1:0] div_rem;

    // Wheel travel helpers
    logic [31:0] du, dm;
    logic        dneg;
    logic [51:0] wmag;

    // Combine helpers
    logic signed [ddo_pkg::TRV_W:0] fsum, fsum_adj, ddiff;
    logic signed [ddo_pkg::TRV_W-1:0] fd;
    logic [ddo_pkg::TRV_W:0] dmag;
    logic [38:0] dsat;

    // CORDIC helpers
    logic [31:0] cor_a;
    logic        cor_flip;
    logic signed [33:0] shx, shy, cs, sn, cs_abs, sn_abs;
    logic signed [32:0] cat;

    // Position helpers
    logic               p_neg;
    logic signed [64:0] p_signed, p_shift, p_sum;
    logic [31:0]        p_pos;

    assign s_tready  = (state_reg == ddo_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // Divider: shift one numerator bit into the remainder, subtract if it fits
    always_comb begin
        div_r2  = {rem_reg, num_reg[ddo_pkg::DIV_W-1]};
        div_sub = div_r2 - {1'b0, dvs_reg};
        div_ge  = (div_r2 >= {1'b0, dvs_reg});
        div_num = {num_reg[ddo_pkg::DIV_W-2:0], div_ge};
        div_rem = div_ge ? div_sub[ddo_pkg::DVS_W-1:0] : div_r2[ddo_pkg::DVS_W-1:0];
    end

    // Wheel tick delta, travel magnitude, and mean/difference of both wheels
    always_comb begin
        du    = wsel_reg ? (in_l_reg - last_l_reg) : (in_r_reg - last_r_reg);
        dneg  = du[31];
        dm    = dneg ? (32'd0 - du) : du;
        wmag  = acc_reg[51:0] + {20'd0, prod_reg[63:32]};
        fsum  = (ddo_pkg::TRV_W+1)'(dr_reg) + (ddo_pkg::TRV_W+1)'(dl_reg);
        fsum_adj = fsum + {{ddo_pkg::TRV_W{1'b0}}, fsum[ddo_pkg::TRV_W]};
        fd    = fsum_adj[ddo_pkg::TRV_W:1];
        ddiff = (ddo_pkg::TRV_W+1)'(dr_reg) - (ddo_pkg::TRV_W+1)'(dl_reg);
        dmag  = ddiff[ddo_pkg::TRV_W] ? (0 - ddiff) : ddiff;
        dsat  = (|dmag[ddo_pkg::TRV_W:39]) ? 39'h7F_FFFF_FFFF : dmag[38:0];
    end

    // CORDIC: fold the angle and form one rotation
    always_comb begin
        cor_a    = yaw_reg & ANGLE_KEEP;
        cor_flip = (cor_a[31:30] == 2'b01) || (cor_a[31:30] == 2'b10);
        if (cor_flip) begin
            cor_a = cor_a - 32'h8000_0000;
        end
        shx    = cx_reg >>> cnt_reg[ddo_pkg::COR_IW-1:0];
        shy    = cy_reg >>> cnt_reg[ddo_pkg::COR_IW-1:0];
        cat    = {1'b0, ddo_pkg::atan_turn(cnt_reg[ddo_pkg::COR_IW-1:0])};
        cs     = flip_reg ? -cx_reg : cx_reg;
        sn     = flip_reg ? -cy_reg : cy_reg;
        cs_abs = cs[33] ? -cs : cs;
        sn_abs = sn[33] ? -sn : sn;
    end

    // Position step: signed product, floor shift by 30, saturating add
    always_comb begin
        p_neg    = fneg_reg ^ ((state_reg == ddo_pkg::ST_PX_ADD) ? cs[33] : sn[33]);
        p_signed = p_neg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
        p_shift  = p_signed >>> 30;
        p_pos    = (state_reg == ddo_pkg::ST_PX_ADD) ? pos_x_reg : pos_y_reg;
        p_sum    = $signed({{33{p_pos[31]}}, p_pos}) + p_shift;
    end

    // Multiplier operands per step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ddo_pkg::ST_W_MUL: begin
                mul_a = dm;
                mul_b = {16'd0, (radius_reg == 16'd0) ? 16'd1 : radius_reg};
            end
            ddo_pkg::ST_W_HI: begin
                mul_a = num_reg[63:32];
                mul_b = ddo_pkg::TWO_PI_Q16;
            end
            ddo_pkg::ST_W_LO: begin
                mul_a = num_reg[31:0];
                mul_b = ddo_pkg::TWO_PI_Q16;
            end
            ddo_pkg::ST_FS_LO: begin
                mul_a = fmag_reg[31:0];
                mul_b = ddo_pkg::US_PER_S;
            end
            ddo_pkg::ST_FS_HI: begin
                mul_a = {28'd0, fmag_reg[35:32]};
                mul_b = ddo_pkg::US_PER_S;
            end
            ddo_pkg::ST_YR_LO: begin
                mul_a = rad_reg[31:0];
                mul_b = ddo_pkg::US_PER_S;
            end
            ddo_pkg::ST_YR_HI: begin
                mul_a = {20'd0, rad_reg[43:32]};
                mul_b = ddo_pkg::US_PER_S;
            end
            ddo_pkg::ST_INC_HI: begin
                mul_a = rad_reg[55:24];
                mul_b = ddo_pkg::TURN_PER_RAD;
            end
            ddo_pkg::ST_INC_LO: begin
                mul_a = {8'd0, rad_reg[23:0]};
                mul_b = ddo_pkg::TURN_PER_RAD;
            end
            ddo_pkg::ST_PX_MUL: begin
                mul_a = fdc_mag_reg;
                mul_b = cs_abs[31:0];
            end
            ddo_pkg::ST_PX_ADD: begin
                mul_a = fdc_mag_reg;
                mul_b = sn_abs[31:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ddo_pkg::ST_IDLE:     if (s_tvalid) state_next = ddo_pkg::ST_W_MUL;
            ddo_pkg::ST_W_MUL:    state_next = ddo_pkg::ST_W_LOAD;
            ddo_pkg::ST_W_LOAD:   state_next = ddo_pkg::ST_W_DIV;
            ddo_pkg::ST_W_DIV:    if (cnt_reg == DIV_LAST) state_next = ddo_pkg::ST_W_HI;
            ddo_pkg::ST_W_HI:     state_next = ddo_pkg::ST_W_LO;
            ddo_pkg::ST_W_LO:     state_next = ddo_pkg::ST_W_SUM;
            ddo_pkg::ST_W_SUM:    state_next = wsel_reg ? ddo_pkg::ST_COMB : ddo_pkg::ST_W_MUL;
            ddo_pkg::ST_COMB:     state_next = ddo_pkg::ST_RAD_DIV;
            ddo_pkg::ST_RAD_DIV:  if (cnt_reg == DIV_LAST) state_next = ddo_pkg::ST_RAD_SAVE;
            ddo_pkg::ST_RAD_SAVE: begin
                state_next = (dt_reg == 24'd0) ? ddo_pkg::ST_INC_HI : ddo_pkg::ST_FS_LO;
            end
            ddo_pkg::ST_FS_LO: begin
                state_next = (|fmag_reg[ddo_pkg::TRV_W-1:36]) ? ddo_pkg::ST_YR_LO
                                                               : ddo_pkg::ST_FS_HI;
            end
            ddo_pkg::ST_FS_HI:    state_next = ddo_pkg::ST_FS_LOAD;
            ddo_pkg::ST_FS_LOAD:  state_next = ddo_pkg::ST_FS_DIV;
            ddo_pkg::ST_FS_DIV:   if (cnt_reg == DIV_LAST) state_next = ddo_pkg::ST_YR_LO;
            ddo_pkg::ST_YR_LO: begin
                state_next = (|rad_reg[63:44]) ? ddo_pkg::ST_INC_HI : ddo_pkg::ST_YR_HI;
            end
            ddo_pkg::ST_YR_HI:    state_next = ddo_pkg::ST_YR_LOAD;
            ddo_pkg::ST_YR_LOAD:  state_next = ddo_pkg::ST_YR_DIV;
            ddo_pkg::ST_YR_DIV:   if (cnt_reg == DIV_LAST) state_next = ddo_pkg::ST_INC_HI;
            ddo_pkg::ST_INC_HI:   state_next = ddo_pkg::ST_INC_LO;
            ddo_pkg::ST_INC_LO:   state_next = ddo_pkg::ST_INC_SUM;
            ddo_pkg::ST_INC_SUM:  state_next = ddo_pkg::ST_COR_INIT;
            ddo_pkg::ST_COR_INIT: state_next = ddo_pkg::ST_COR_STEP;
            ddo_pkg::ST_COR_STEP: if (cnt_reg == COR_LAST) state_next = ddo_pkg::ST_PX_MUL;
            ddo_pkg::ST_PX_MUL:   state_next = ddo_pkg::ST_PX_ADD;
            ddo_pkg::ST_PX_ADD:   state_next = ddo_pkg::ST_PY_ADD;
            ddo_pkg::ST_PY_ADD:   state_next = ddo_pkg::ST_DONE;
            ddo_pkg::ST_DONE:     if (!m_valid_reg || m_tready) state_next = ddo_pkg::ST_IDLE;
            default:              state_next = ddo_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates per step
    always_comb begin
        radius_next  = radius_reg;
        axle_next    = axle_reg;
        tpr_next     = tpr_reg;
        in_r_next    = in_r_reg;
        in_l_next    = in_l_reg;
        dt_next      = dt_reg;
        last_r_next  = last_r_reg;
        last_l_next  = last_l_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        yaw_next     = yaw_reg;
        wsel_next    = wsel_reg;
        dr_next      = dr_reg;
        dl_next      = dl_reg;
        fmag_next    = fmag_reg;
        fneg_next    = fneg_reg;
        yneg_next    = yneg_reg;
        fdc_mag_next = fdc_mag_reg;
        rad_next     = rad_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        cnt_next     = cnt_reg;
        prod_next    = 64'(mul_a) * 64'(mul_b);
        acc_next     = acc_reg;
        fspeed_next  = fspeed_reg;
        yrate_next   = yrate_reg;
        inc_next     = inc_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        flip_next    = flip_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_valid_next = m_valid_reg;

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // Take register writes
        if (cfg_valid) begin
            case (cfg_index)
                ddo_pkg::CFG_WHEEL_RADIUS:  radius_next = cfg_data[15:0];
                ddo_pkg::CFG_AXLE_WIDTH:    axle_next   = cfg_data;
                ddo_pkg::CFG_TICKS_PER_REV: tpr_next    = cfg_data[15:0];
                default: ;
            endcase
        end

        case (state_reg)
            ddo_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    in_r_next   = s_tdata[31:0];
                    in_l_next   = s_tdata[63:32];
                    dt_next     = s_tdata[87:64];
                    wsel_next   = 1'b0;
                    fspeed_next = '0;
                    yrate_next  = '0;
                end
            end
            ddo_pkg::ST_W_LOAD: begin
                num_next = {prod_reg[47:0], 16'd0};
                rem_next = '0;
                dvs_next = {8'd0, (tpr_reg == 16'd0) ? 16'd1 : tpr_reg};
                cnt_next = '0;
            end
            ddo_pkg::ST_W_DIV, ddo_pkg::ST_RAD_DIV, ddo_pkg::ST_FS_DIV,
            ddo_pkg::ST_YR_DIV: begin
                num_next = div_num;
                rem_next = div_rem;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    if (state_reg == ddo_pkg::ST_FS_DIV) begin
                        fspeed_next = ddo_pkg::signed_sat(fneg_reg, div_num);
                    end else if (state_reg == ddo_pkg::ST_YR_DIV) begin
                        yrate_next = ddo_pkg::signed_sat(yneg_reg, {8'd0, div_num[63:8]});
                    end
                end
            end
            ddo_pkg::ST_W_LO, ddo_pkg::ST_FS_HI, ddo_pkg::ST_YR_HI,
            ddo_pkg::ST_INC_LO: begin
                acc_next = prod_reg;
            end
            ddo_pkg::ST_W_SUM: begin
                if (wsel_reg) begin
                    dl_next = dneg ? -$signed({4'd0, wmag}) : $signed({4'd0, wmag});
                end else begin
                    dr_next = dneg ? -$signed({4'd0, wmag}) : $signed({4'd0, wmag});
                end
                wsel_next = 1'b1;
            end
            ddo_pkg::ST_COMB: begin
                fneg_next    = fd[ddo_pkg::TRV_W-1];
                fmag_next    = fd[ddo_pkg::TRV_W-1] ? (0 - fd) : fd;
                fdc_mag_next = (|fmag_next[ddo_pkg::TRV_W-1:32]) ? 32'hFFFF_FFFF
                                                                  : fmag_next[31:0];
                yneg_next    = ddiff[ddo_pkg::TRV_W];
                num_next     = {1'b0, dsat, 24'd0};
                rem_next     = '0;
                dvs_next     = {6'd0, (axle_reg == 18'd0) ? 18'd1 : axle_reg};
                cnt_next     = '0;
            end
            ddo_pkg::ST_RAD_SAVE: begin
                rad_next = num_reg;
            end
            ddo_pkg::ST_FS_LO: begin
                if (|fmag_reg[ddo_pkg::TRV_W-1:36]) begin
                    fspeed_next = ddo_pkg::signed_sat(fneg_reg, '1);
                end
            end
            ddo_pkg::ST_FS_LOAD, ddo_pkg::ST_YR_LOAD: begin
                num_next = acc_reg + {prod_reg[31:0], 32'd0};
                rem_next = '0;
                dvs_next = dt_reg;
                cnt_next = '0;
            end
            ddo_pkg::ST_YR_LO: begin
                if (|rad_reg[63:44]) begin
                    yrate_next = ddo_pkg::signed_sat(yneg_reg, '1);
                end
            end
            ddo_pkg::ST_INC_SUM: begin
                inc_next = yneg_reg ? (32'd0 - (acc_reg[31:0] + prod_reg[55:24]))
                                    : (acc_reg[31:0] + prod_reg[55:24]);
            end
            ddo_pkg::ST_COR_INIT: begin
                cx_next   = ddo_pkg::CORDIC_GAIN_Q30;
                cy_next   = '0;
                cz_next   = $signed({cor_a[31], cor_a});
                flip_next = cor_flip;
                cnt_next  = '0;
            end
            ddo_pkg::ST_COR_STEP: begin
                if (!cz_reg[32]) begin
                    cx_next = cx_reg - shy;
                    cy_next = cy_reg + shx;
                    cz_next = cz_reg - cat;
                end else begin
                    cx_next = cx_reg + shy;
                    cy_next = cy_reg - shx;
                    cz_next = cz_reg + cat;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ddo_pkg::ST_PX_ADD: begin
                pos_x_next = ddo_pkg::sat32(p_sum);
            end
            ddo_pkg::ST_PY_ADD: begin
                pos_y_next = ddo_pkg::sat32(p_sum);
            end
            ddo_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    yaw_next     = yaw_reg + inc_reg;
                    last_r_next  = in_r_reg;
                    last_l_next  = in_l_reg;
                    m_data_next  = {yrate_reg, fspeed_reg, yaw_next[31:16],
                                    pos_y_reg, pos_x_reg};
                    m_user_next  = (dt_reg == 24'd0);
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control and pose state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ddo_pkg::ST_IDLE;
            radius_reg  <= 16'd8061;
            axle_reg    <= 18'd15073;
            tpr_reg     <= 16'd2160;
            last_r_reg  <= '0;
            last_l_reg  <= '0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            yaw_reg     <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            wsel_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            radius_reg  <= radius_next;
            axle_reg    <= axle_next;
            tpr_reg     <= tpr_next;
            last_r_reg  <= last_r_next;
            last_l_reg  <= last_l_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            yaw_reg     <= yaw_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            wsel_reg    <= wsel_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        in_r_reg    <= in_r_next;
        in_l_reg    <= in_l_next;
        dt_reg      <= dt_next;
        dr_reg      <= dr_next;
        dl_reg      <= dl_next;
        fmag_reg    <= fmag_next;
        fneg_reg    <= fneg_next;
        yneg_reg    <= yneg_next;
        fdc_mag_reg <= fdc_mag_next;
        rad_reg     <= rad_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        fspeed_reg  <= fspeed_next;
        yrate_reg   <= yrate_next;
        inc_reg     <= inc_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        flip_reg    <= flip_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

endmodule

@@ design/ddo_checker.sv @@
`timescale 1ns / 1ps

module ddo_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic         m_tuser
);

    // Hold a stalled result
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // A request keeps the block busy on the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // No result appears right after a request
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

    // Zero elapsed time forces both speeds to zero
    a_no_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[111:80] == 32'd0) && (m_tdata[143:112] == 32'd0))
        else $error("speed nonzero with zero elapsed time");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
